@@ rtl/pptt_pkg.sv @@
// Shared types, codes and constants of the pin pulse timer table.
package pptt_pkg;

    localparam int SLOTS_DEF = 8;
    localparam logic [31:0] DEFAULT_DURATION_RESET = 32'd1000;

    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_START     = 2'd1;
    localparam logic [1:0] REQ_START_DEF = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] remaining;
        logic        level;
        logic [7:0]  pin;
    } entry_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pin;
        logic       level;
        logic [1:0] status;
        logic       last;
    } res_t;

endpackage

@@ rtl/pptt_slot_ram.sv @@
// Slot memory: pin, level and remaining count per slot, registered read.
module pptt_slot_ram
    import pptt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read word while the walk is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/pptt_ctrl.sv @@
// Sequencer: walks the slot memory per item, keeps active flags and default.
module pptt_ctrl
    import pptt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_req,
    input  logic [7:0]    s_pin,
    input  logic          s_lvl,
    input  logic [31:0]   s_dur,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    output logic          rd_en,
    output logic [IW-1:0] rd_addr,
    input  entry_t        rd_data,
    output logic          wr_en,
    output logic [IW-1:0] wr_addr,
    output entry_t        wr_data,
    input  logic          out_free,
    output logic          push,
    output res_t          push_res
);

    localparam int CW = $clog2(SLOTS + 1);

    state_t        state_reg, state_next;
    logic          is_tick_reg, is_tick_next;
    logic [7:0]    pin_reg, pin_next;
    logic          lvl_reg, lvl_next;
    logic [31:0]   dur_reg, dur_next;
    logic          busy_reg, busy_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          proc_valid_reg, proc_valid_next;
    logic [IW-1:0] proc_idx_reg, proc_idx_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic          held_valid_reg, held_valid_next;
    res_t          held_reg, held_next;
    logic [31:0]   dflt_reg, dflt_next;

    logic proc_active, expire, new_res, adv, walk_done;
    logic iss_more, fin_push_needed, fin_done, start_ok;
    logic accept;
    res_t rel_res;

    assign proc_active     = active_reg[proc_idx_reg];
    assign expire          = (rd_data.remaining <= 32'd1);
    assign new_res         = (state_reg == ST_WALK) && proc_valid_reg && is_tick_reg
                             && proc_active && expire;
    // Stall the walk only when a second release meets a full output register.
    assign adv             = !(new_res && held_valid_reg && !out_free);
    assign walk_done       = (state_reg == ST_WALK) && proc_valid_reg && adv
                             && (proc_idx_reg == IW'(SLOTS - 1));
    assign iss_more        = (iss_reg != CW'(SLOTS));
    assign fin_push_needed = !is_tick_reg || held_valid_reg;
    assign fin_done        = !fin_push_needed || out_free;
    assign start_ok        = !busy_reg && free_found_reg;
    assign accept          = s_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        rel_res        = '0;
        rel_res.kind   = KIND_RELEASE;
        rel_res.pin    = rd_data.pin;
        rel_res.level  = ~rd_data.level;
        rel_res.status = STATUS_OK;
        rel_res.last   = 1'b0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_req == REQ_TICK || s_req == REQ_START
                               || s_req == REQ_START_DEF))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs towards the memory and the output stage.
    always_comb
    begin
        s_ready  = (state_reg == ST_IDLE);
        rd_en    = 1'b0;
        rd_addr  = iss_reg[IW-1:0];
        wr_en    = 1'b0;
        wr_addr  = proc_idx_reg;
        wr_data  = rd_data;
        push     = 1'b0;
        push_res = held_reg;
        case (state_reg)
            ST_WALK:
            begin
                rd_en = adv && iss_more;
                if (proc_valid_reg && is_tick_reg && proc_active && !expire && adv)
                begin
                    wr_en             = 1'b1;
                    wr_data.remaining = rd_data.remaining - 32'd1;
                end
                if (new_res && held_valid_reg && adv)
                begin
                    push          = 1'b1;
                    push_res.last = 1'b0;
                end
            end
            ST_FINISH:
            begin
                if (fin_push_needed && out_free)
                begin
                    push = 1'b1;
                    if (is_tick_reg)
                    begin
                        push_res.last = 1'b1;
                    end
                    else
                    begin
                        push_res.kind  = KIND_REPLY;
                        push_res.pin   = pin_reg;
                        push_res.last  = 1'b1;
                        push_res.level = start_ok ? lvl_reg : 1'b0;
                        if (busy_reg)
                        begin
                            push_res.status = STATUS_BUSY;
                        end
                        else if (!free_found_reg)
                        begin
                            push_res.status = STATUS_FULL;
                        end
                        else
                        begin
                            push_res.status = STATUS_OK;
                        end
                        if (start_ok)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = free_idx_reg;
                            wr_data.pin       = pin_reg;
                            wr_data.level     = lvl_reg;
                            wr_data.remaining = dur_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        is_tick_next    = is_tick_reg;
        pin_next        = pin_reg;
        lvl_next        = lvl_reg;
        dur_next        = dur_reg;
        busy_next       = busy_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        iss_next        = iss_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        active_next     = active_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        dflt_next       = cfg_we ? cfg_wdata : dflt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_tick_next    = (s_req == REQ_TICK);
                    pin_next        = s_pin;
                    lvl_next        = s_lvl;
                    dur_next        = (s_req == REQ_START_DEF) ? dflt_reg : s_dur;
                    busy_next       = 1'b0;
                    free_found_next = 1'b0;
                    iss_next        = '0;
                    proc_valid_next = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (adv)
                begin
                    if (iss_more)
                    begin
                        iss_next        = iss_reg + CW'(1);
                        proc_valid_next = 1'b1;
                        proc_idx_next   = iss_reg[IW-1:0];
                    end
                    else
                    begin
                        proc_valid_next = 1'b0;
                    end
                    if (proc_valid_reg)
                    begin
                        if (is_tick_reg)
                        begin
                            if (new_res)
                            begin
                                active_next[proc_idx_reg] = 1'b0;
                                held_valid_next           = 1'b1;
                                held_next                 = rel_res;
                            end
                        end
                        else if (proc_active)
                        begin
                            if (rd_data.pin == pin_reg)
                            begin
                                busy_next = 1'b1;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = proc_idx_reg;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (fin_done)
                begin
                    held_valid_next = 1'b0;
                    if (!is_tick_reg && start_ok)
                    begin
                        active_next[free_idx_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iss_reg        <= '0;
            proc_valid_reg <= 1'b0;
            active_reg     <= '0;
            held_valid_reg <= 1'b0;
            dflt_reg       <= DEFAULT_DURATION_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            proc_valid_reg <= proc_valid_next;
            active_reg     <= active_next;
            held_valid_reg <= held_valid_next;
            dflt_reg       <= dflt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_tick_reg    <= is_tick_next;
        pin_reg        <= pin_next;
        lvl_reg        <= lvl_next;
        dur_reg        <= dur_next;
        busy_reg       <= busy_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        proc_idx_reg   <= proc_idx_next;
        held_reg       <= held_next;
    end

endmodule

@@ rtl/pptt_out_stage.sv @@
// Output register: holds one result word until the master side takes it.
module pptt_out_stage
    import pptt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  res_t        push_res,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;

    assign free = !out_valid_reg || m_tready;

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_res_reg <= push_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.status, out_res_reg.level, out_res_reg.pin};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

endmodule

@@ rtl/pin_pulse_timer_table.sv @@
// Top level of the pin pulse timer table: slot memory, sequencer, output register.
//
//   channel | direction | tdata (low bit up)                  | tuser     | tlast
//   s_*     | in        | pin[7:0] level[8] duration[40:9]    | req_type  | -
//   m_*     | out       | out_pin[7:0] out_level[8] status[10:9] | kind   | last
//   cfg_*   | in        | cfg_wdata = default_duration, written when cfg_we
//
// A tick or a start is taken only in the idle state; the block then issues the
// first read, walks the slot memory one entry per cycle through its single read
// port unless a release stall holds the walk, finishes, and returns to idle to
// take the next word. A request code of 3 is taken and dropped.
// Reset clears the active flags at once; no clearing pass over the memory.
// A stalled master side halts the walk only when a second release is due
// while the output register still holds an untaken word; the finishing cycle
// waits, when a final word is due, until the output register can take it.
module pin_pulse_timer_table
    import pptt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pin[7:0], level[8], duration[40:9], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_pin[7:0], out_level[8], status[10:9], zero fill
    output logic [0:0]  m_tuser,   // kind[0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic          out_free;
    logic          push;
    res_t          push_res;

    // Hold per-slot pin, level and remaining count.
    pptt_slot_ram #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Walk the slots for each word: count down on a tick, check and store on a start.
    pptt_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_req     (s_tuser),
        .s_pin     (s_tdata[7:0]),
        .s_lvl     (s_tdata[8]),
        .s_dur     (s_tdata[40:9]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_free  (out_free),
        .push      (push),
        .push_res  (push_res)
    );

    // Present result words on the master side.
    pptt_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/pptt_checker.sv @@
// Port-level checks on the pin pulse timer table, bound to the top level.
module pptt_checker
    import pptt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A start reply is always the only, and so the final, word of its item.
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_REPLY |-> m_tlast)
        else $error("start reply without last");

    // A refused start drives no level.
    a_refused_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_REPLY && m_tdata[10:9] != STATUS_OK
        |-> !m_tdata[8])
        else $error("refused start with level set");

    // A release carries status zero.
    a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_RELEASE |-> m_tdata[10:9] == STATUS_OK)
        else $error("release with non-zero status");

    // A tick or start taken in occupies the block on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == REQ_TICK || s_tuser == REQ_START
                                 || s_tuser == REQ_START_DEF) |=> !s_tready)
        else $error("input ready straight after accepting a request");

endmodule

bind pin_pulse_timer_table pptt_checker u_pptt_checker (.*);

@@ verif/tb_pin_pulse_timer_table.sv @@
// Self-checking testbench of the pin pulse timer table: directed table, random phases, predictor.
module tb_pin_pulse_timer_table;
    import pptt_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    // Request code that the block takes and drops; the package leaves it unnamed.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Leave a wide margin over the walk through the slots.
    localparam int SETTLE_CYCLES = 4 * (SLOTS + 3);
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    // Remaining count above which a pulse is treated as never expiring in this run.
    localparam logic [31:0] LONG_PULSE = 32'd64;
    localparam int MAX_LONG = 3;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        logic [1:0]  req;
        logic [7:0]  pin;
        logic        lvl;
        logic [31:0] dur;
        bit          typed;
        res_t        want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = REQ_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    // Travel with the offered word so that the acceptance monitor knows how to treat it.
    bit          row_typed = 1'b0;
    res_t        row_want = '0;

    // Predictor copy of the slot table and of the default length register.
    bit          pulse_on   [SLOTS];
    logic [7:0]  pulse_pin  [SLOTS];
    logic        pulse_lvl  [SLOTS];
    logic [31:0] pulse_left [SLOTS];
    logic [31:0] dflt_len = DEFAULT_DURATION_RESET;

    // Result words still owed by the block, oldest first.
    res_t        pending_words[$];
    stim_row_t   dir_rows[$];

    int          fail_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_off = 1'b0;

    pin_pulse_timer_table #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),    // pin[7:0], level[8], duration[40:9], zero fill
        .s_tuser(s_tuser),    // req_type[1:0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),    // out_pin[7:0], out_level[8], status[10:9], zero fill
        .m_tuser(m_tuser),    // kind[0]
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            pulse_on[i]   = 1'b0;
            pulse_pin[i]  = '0;
            pulse_lvl[i]  = 1'b0;
            pulse_left[i] = '0;
        end
    end

    // Give up after a fixed time, far beyond the slowest correct run.
    initial
    begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic res_t reply(logic [7:0] pin, logic lvl, logic [1:0] status);
        res_t w;
        w.kind   = KIND_REPLY;
        w.pin    = pin;
        w.level  = lvl;
        w.status = status;
        w.last   = 1'b1;
        return w;
    endfunction

    function automatic stim_row_t row(logic [1:0] req, logic [7:0] pin, logic lvl,
                                      logic [31:0] dur, bit typed, res_t want);
        stim_row_t r;
        r.req   = req;
        r.pin   = pin;
        r.lvl   = lvl;
        r.dur   = dur;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Pulses that will outlive the run; keep their number bounded so the table keeps moving.
    function automatic int count_long();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (pulse_on[i] && pulse_left[i] > LONG_PULSE)
                n++;
        return n;
    endfunction

    // Advance the predicted table by one accepted word and queue the results it owes.
    task automatic advance_table(input logic [1:0] req, input logic [7:0] pin,
                                 input logic lvl, input logic [31:0] dur,
                                 input bit typed, input res_t typed_word);
        res_t words[$];
        res_t w;
        int   free_slot;
        bit   busy;
        free_slot = -1;
        busy = 1'b0;
        w = '0;
        if (req == REQ_TICK)
        begin
            // Walk in slot order: releases leave in ascending slot index.
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!pulse_on[i])
                    continue;
                if (pulse_left[i] <= 32'd1)
                begin
                    pulse_on[i] = 1'b0;
                    w.kind   = KIND_RELEASE;
                    w.pin    = pulse_pin[i];
                    w.level  = ~pulse_lvl[i];
                    w.status = STATUS_OK;
                    w.last   = 1'b0;
                    words.push_back(w);
                end
                else
                    pulse_left[i] = pulse_left[i] - 32'd1;
            end
        end
        else if (req == REQ_START || req == REQ_START_DEF)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (pulse_on[i])
                begin
                    if (pulse_pin[i] == pin)
                        busy = 1'b1;
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            w.kind = KIND_REPLY;
            w.pin  = pin;
            w.last = 1'b0;
            // Busy wins over full; a refused start drives nothing, so its level reads 0.
            if (busy)
            begin
                w.level  = 1'b0;
                w.status = STATUS_BUSY;
            end
            else if (free_slot < 0)
            begin
                w.level  = 1'b0;
                w.status = STATUS_FULL;
            end
            else
            begin
                pulse_on[free_slot]   = 1'b1;
                pulse_pin[free_slot]  = pin;
                pulse_lvl[free_slot]  = lvl;
                pulse_left[free_slot] = (req == REQ_START) ? dur : dflt_len;
                w.level  = lvl;
                w.status = STATUS_OK;
            end
            words.push_back(w);
        end
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        if (typed)
        begin
            words.delete();
            words.push_back(typed_word);
        end
        foreach (words[k])
            pending_words.push_back(words[k]);
    endtask

    // Offer one word after a drawn gap and hold it until the block takes it.
    task automatic send_word(input logic [1:0] req, input logic [7:0] pin, input logic lvl,
                             input logic [31:0] dur, input bit typed, input res_t want);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {7'd0, dur, lvl, pin};
        s_tuser   <= req;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    // Wait for every owed word, then let the walk of any silent tick run out.
    task automatic settle();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_default(input logic [31:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        dflt_len = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random words, mostly ticks and starts on a handful of pins so that busy and full recur.
    task automatic run_phase(input int words);
        int          counted;
        int          pick;
        logic [1:0]  req;
        logic [7:0]  pin;
        logic        lvl;
        logic [31:0] dur;
        counted = 0;
        while (counted < words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                req = REQ_TICK;
            else if (pick < 80)
                req = REQ_START;
            else if (pick < 95)
                req = REQ_START_DEF;
            else
                req = REQ_UNUSED;
            pin = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 11))
                                             : 8'($urandom_range(0, 255));
            lvl = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 85)
                dur = $urandom_range(0, 12);
            else if (pick < 95)
                dur = $urandom_range(13, 40);
            else
                dur = $urandom();
            // Cap pulses that would never expire: fall back to a short given length.
            if (count_long() >= MAX_LONG)
            begin
                if (dur > LONG_PULSE)
                    dur = $urandom_range(0, 12);
                if (req == REQ_START_DEF && dflt_len > LONG_PULSE)
                    req = REQ_START;
            end
            send_word(req, pin, lvl, dur, 1'b0, '0);
            if (req != REQ_UNUSED)
                counted++;
        end
    endtask

    // Acceptance monitor: predict at the edge that takes the word.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            advance_table(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[40:9],
                          row_typed, row_want);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result monitor: compare each taken word with the oldest owed one.
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word: kind %0h pin %0h level %0h status %0h last %0h",
                       m_tuser[0], m_tdata[7:0], m_tdata[8], m_tdata[10:9], m_tlast);
                fail_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                check_field("kind", 32'(w.kind), 32'(m_tuser[0]));
                check_field("out_pin", 32'(w.pin), 32'(m_tdata[7:0]));
                check_field("out_level", 32'(w.level), 32'(m_tdata[8]));
                check_field("status", 32'(w.status), 32'(m_tdata[10:9]));
                check_field("last", 32'(w.last), 32'(m_tlast));
            end
        end
    end

    // Receiver: draw a wait per word; once, hold off long enough to back the block up.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    // Sender and sequence of phases.
    initial
    begin
        // Empty table, then a busy retry and the shortest pulses.
        dir_rows.push_back(row(REQ_TICK, 8'd0, 1'b0, 32'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_START, 8'd0, 1'b1, 32'd0, 1'b1,
                               reply(8'd0, 1'b1, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd0, 1'b0, 32'd5, 1'b1,
                               reply(8'd0, 1'b0, STATUS_BUSY)));
        dir_rows.push_back(row(REQ_TICK, 8'd0, 1'b0, 32'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_START, 8'd255, 1'b0, 32'd1, 1'b1,
                               reply(8'd255, 1'b0, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd1, 1'b1, 32'hFFFF_FFFF, 1'b1,
                               reply(8'd1, 1'b1, STATUS_OK)));
        // Default length from reset; the duration field must be ignored.
        dir_rows.push_back(row(REQ_START_DEF, 8'd2, 1'b1, 32'd3, 1'b1,
                               reply(8'd2, 1'b1, STATUS_OK)));
        dir_rows.push_back(row(REQ_UNUSED, 8'd3, 1'b1, 32'd7, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 8'd0, 1'b0, 32'd0, 1'b0, '0));
        // Fill the table; pin 10 lands in slot 0, ahead of the older pins.
        dir_rows.push_back(row(REQ_START, 8'd10, 1'b1, 32'd2, 1'b1,
                               reply(8'd10, 1'b1, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd11, 1'b0, 32'd3, 1'b1,
                               reply(8'd11, 1'b0, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd12, 1'b1, 32'd2, 1'b1,
                               reply(8'd12, 1'b1, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd13, 1'b0, 32'd1, 1'b1,
                               reply(8'd13, 1'b0, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd14, 1'b1, 32'd3, 1'b1,
                               reply(8'd14, 1'b1, STATUS_OK)));
        dir_rows.push_back(row(REQ_START, 8'd15, 1'b0, 32'd2, 1'b1,
                               reply(8'd15, 1'b0, STATUS_OK)));
        // Full, then busy while also full.
        dir_rows.push_back(row(REQ_START, 8'd20, 1'b1, 32'd4, 1'b1,
                               reply(8'd20, 1'b0, STATUS_FULL)));
        dir_rows.push_back(row(REQ_START, 8'd1, 1'b1, 32'd4, 1'b1,
                               reply(8'd1, 1'b0, STATUS_BUSY)));
        dir_rows.push_back(row(REQ_START_DEF, 8'd12, 1'b0, 32'd0, 1'b1,
                               reply(8'd12, 1'b0, STATUS_BUSY)));
        // Several releases per tick, in slot order.
        dir_rows.push_back(row(REQ_TICK, 8'd0, 1'b0, 32'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 8'd0, 1'b0, 32'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_TICK, 8'd0, 1'b0, 32'd0, 1'b0, '0));
        dir_rows.push_back(row(REQ_START, 8'd128, 1'b1, 32'd4, 1'b1,
                               reply(8'd128, 1'b1, STATUS_OK)));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].pin, dir_rows[i].lvl,
                      dir_rows[i].dur, dir_rows[i].typed, dir_rows[i].want);

        // Zero default: every default start expires on the next tick.
        write_default(32'd0);
        run_phase(96);

        // All-ones default, with no idling on either side.
        write_default(32'hFFFF_FFFF);
        no_idle = 1'b1;
        run_phase(96);
        no_idle = 1'b0;

        // Hold the receiver off while words keep coming, so the input stalls.
        write_default(32'd5);
        hold_off = 1'b1;
        run_phase(96);

        write_default(32'($urandom_range(1, 30)));
        run_phase(96);

        write_default(32'd1);
        run_phase(96);

        settle();
        if (pending_words.size() != 0)
        begin
            $error("%0d result words never arrived", pending_words.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
